// ===== rtl/core/gomi_pkg.sv =====
// Package for the gripper open intent marker.
// Holds the widths, register indices and the state and result types shared by the modules.
package gomi_pkg;

  localparam int INDEX_BITS   = 16;
  localparam int OUT_IDX_BITS = 16;
  localparam int WIDTH_BITS   = 17;
  localparam int SLACK_BITS   = 10;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 17;

  localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_LIMIT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLACK      = 2'd1;

  localparam logic [WIDTH_BITS-1:0] OPEN_LIMIT_RESET = 17'd79900;
  localparam logic [SLACK_BITS-1:0] SLACK_RESET      = 10'd100;

  typedef logic [INDEX_BITS-1:0]   index_t;
  typedef logic [OUT_IDX_BITS-1:0] out_index_t;
  typedef logic [WIDTH_BITS-1:0]   width_t;
  typedef logic [SLACK_BITS-1:0]   slack_t;

  typedef struct packed {
    width_t prev_width;
    logic   have_prev;
    logic   in_run;
    index_t run_start;
    logic   start_below;
    logic   reach_found;
    index_t sample_counter;
  } run_state_t;

  typedef struct packed {
    out_index_t sample_index;
    logic       above_threshold;
    logic       fill_valid;
    out_index_t fill_first;
    out_index_t fill_last;
  } result_t;

endpackage

// ===== rtl/core/gomi_cfg_regs.sv =====
// Configuration registers of the gripper open intent marker.
// Depends on gomi_pkg for the register indices and reset values.
module gomi_cfg_regs
  import gomi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output width_t                   open_limit,
  output slack_t                   slack
);

  width_t open_limit_r;
  slack_t slack_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_limit_r <= OPEN_LIMIT_RESET;
      slack_r      <= SLACK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OPEN_LIMIT: open_limit_r <= cfg_data[WIDTH_BITS-1:0];
        REG_SLACK:      slack_r      <= cfg_data[SLACK_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign open_limit = open_limit_r;
  assign slack      = slack_r;

endmodule

// ===== rtl/core/gomi_step.sv =====
// Single-sample step logic: threshold compare, run tracking and backfill range.
// Depends on gomi_pkg for the run state and result types.
module gomi_step
  import gomi_pkg::*;
(
  input  run_state_t state,
  input  width_t     sample_width,
  input  logic       first_sample,
  input  width_t     open_limit,
  input  slack_t     slack,
  output run_state_t state_nxt,
  output result_t    result
);

  localparam index_t INDEX_MAX = {INDEX_BITS{1'b1}};

  logic                  above;
  logic                  fill;
  logic                  rise;
  logic                  hold;
  index_t                idx;
  logic [WIDTH_BITS:0]   prev_plus_slack;
  logic [WIDTH_BITS:0]   cur_plus_slack;

  always_comb begin
    above           = sample_width >= open_limit;
    prev_plus_slack = {1'b0, state.prev_width} + {{(WIDTH_BITS+1-SLACK_BITS){1'b0}}, slack};
    cur_plus_slack  = {1'b0, sample_width} + {{(WIDTH_BITS+1-SLACK_BITS){1'b0}}, slack};
    rise            = {1'b0, sample_width} > prev_plus_slack;
    hold            = cur_plus_slack >= {1'b0, state.prev_width};
    fill            = 1'b0;
    state_nxt       = state;

    if (first_sample || !state.have_prev) begin
      idx                   = '0;
      state_nxt.in_run      = 1'b0;
      state_nxt.reach_found = 1'b0;
      state_nxt.start_below = 1'b0;
      state_nxt.run_start   = '0;
    end else begin
      idx = (state.sample_counter == INDEX_MAX) ? state.sample_counter
                                                : state.sample_counter + 1'b1;
      if (!state.in_run) begin
        if (rise) begin
          state_nxt.in_run      = 1'b1;
          state_nxt.run_start   = state.sample_counter;
          state_nxt.start_below = state.prev_width < open_limit;
          state_nxt.reach_found = above;
          fill                  = above && (state.prev_width < open_limit);
        end
      end else if (hold) begin
        if (!state.reach_found && above) begin
          state_nxt.reach_found = 1'b1;
          fill                  = state.start_below;
        end
      end else begin
        state_nxt.in_run      = 1'b0;
        state_nxt.reach_found = 1'b0;
      end
    end

    state_nxt.prev_width     = sample_width;
    state_nxt.have_prev      = 1'b1;
    state_nxt.sample_counter = idx;

    result.sample_index    = OUT_IDX_BITS'(idx);
    result.above_threshold = above;
    result.fill_valid      = fill;
    result.fill_first      = fill ? OUT_IDX_BITS'(state_nxt.run_start) : '0;
    result.fill_last       = fill ? OUT_IDX_BITS'(idx) : '0;
  end

endmodule

// ===== rtl/core/gripper_open_intent_marker_core.sv =====
// Top level of the gripper open intent marker: input register, step logic, result register.
// Depends on gomi_pkg, gomi_cfg_regs and gomi_step.
//
//   Channel  | Direction | Handshake          | Payload
//   in_      | request   | in_valid/in_stall  | sample_width, first_sample
//   out_     | result    | out_valid/out_stall| index, above, fill range
//   cfg_     | write     | cfg_we             | cfg_index, cfg_data
//
// One request is accepted per cycle while in_stall is low; its result is loaded into the result
// register when the result channel is free and is then offered until it is taken.
// The run state is updated in the same cycle as the result register is loaded.
// Reset is synchronous and returns the configuration registers to their defaults and the run state to zero.
// A stalled result holds the input register, which then stalls the input channel.
module gripper_open_intent_marker_core
  import gomi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  width_t                   in_sample_width,
  input  logic                     in_first_sample,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_index_t               out_sample_index,
  output logic                     out_above_threshold,
  output logic                     out_fill_valid,
  output out_index_t               out_fill_first,
  output out_index_t               out_fill_last,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  width_t     open_limit;
  slack_t     slack;
  logic       s1_valid_r;
  width_t     s1_width_r;
  logic       s1_first_r;
  logic       out_valid_r;
  result_t    result_r;
  run_state_t state_r;
  run_state_t state_nxt;
  result_t    result_nxt;
  logic       out_free;
  logic       advance;
  logic       in_take;

  gomi_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .open_limit (open_limit),
    .slack      (slack)
  );

  gomi_step u_step (
    .state        (state_r),
    .sample_width (s1_width_r),
    .first_sample (s1_first_r),
    .open_limit   (open_limit),
    .slack        (slack),
    .state_nxt    (state_nxt),
    .result       (result_nxt)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_width_r <= in_sample_width;
      s1_first_r <= in_first_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_sample_index    = result_r.sample_index;
  assign out_above_threshold = result_r.above_threshold;
  assign out_fill_valid      = result_r.fill_valid;
  assign out_fill_first      = result_r.fill_first;
  assign out_fill_last       = result_r.fill_last;

endmodule
